>>> src/hvt_pkg.sv
`timescale 1ns / 1ps

package hvt_pkg;

	// fixed-point format of coefficients, components and results
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int ACC_W     = PROD_W + 2;

	localparam int NUM_ROWS  = 4;
	localparam int NUM_COLS  = 4;
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 64;
	localparam int CFG_IDX_W = 8;

	localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1) << FRAC_BITS;
	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// input kind codes
	localparam logic KIND_TUPLE = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	// identity matrix, low and high coefficient of a register
	localparam logic [REG_W-1:0] ID_LO = REG_W'(1) << FRAC_BITS;
	localparam logic [REG_W-1:0] ID_HI = REG_W'(1) << (WORD_W + FRAC_BITS);
	localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = {
		ID_HI, REG_W'(0), ID_LO, REG_W'(0),
		REG_W'(0), ID_HI, REG_W'(0), ID_LO
	};

	typedef logic [NUM_COLS-1:0][WORD_W-1:0] vec_t;
	typedef vec_t [NUM_ROWS-1:0] matrix_t;

	// load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

>>> src/hvt_cfg.sv
`timescale 1ns / 1ps

module hvt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [hvt_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [hvt_pkg::REG_W-1:0]     wr_data,
	output hvt_pkg::matrix_t              matrix
);

	logic [hvt_pkg::NUM_REGS-1:0][hvt_pkg::REG_W-1:0] regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= hvt_pkg::CFG_RESET;
		end else if (wr_en && (wr_index < hvt_pkg::CFG_IDX_W'(hvt_pkg::NUM_REGS))) begin
			regs_q[wr_index[$clog2(hvt_pkg::NUM_REGS)-1:0]] <= wr_data;
		end
	end

	// register 2r+c/2 holds row r, column c, odd columns in the high half
	always_comb begin
		for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				matrix[r][c] = (c % 2 == 1)
					? regs_q[2*r + c/2][hvt_pkg::REG_W-1:hvt_pkg::WORD_W]
					: regs_q[2*r + c/2][hvt_pkg::WORD_W-1:0];
			end
		end
	end

endmodule

>>> src/hvt_row.sv
`timescale 1ns / 1ps

module hvt_row (
	input  logic                       clk,
	input  hvt_pkg::stage_en_t         en,
	input  hvt_pkg::vec_t              coef,
	input  hvt_pkg::vec_t              vec,
	output logic [hvt_pkg::WORD_W-1:0] res,
	output logic                       sat
);

	logic signed [hvt_pkg::PROD_W-1:0] prod_s1 [hvt_pkg::NUM_COLS];
	logic signed [hvt_pkg::PAIR_W-1:0] pair_s2 [2];
	logic signed [hvt_pkg::ACC_W-1:0]  acc_s3;
	logic [hvt_pkg::WORD_W-1:0]        res_s4;
	logic                              sat_s4;

	logic signed [hvt_pkg::ACC_W-1:0]       shifted;
	logic [hvt_pkg::ACC_W-hvt_pkg::WORD_W:0] top_bits;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				prod_s1[c] <= $signed(coef[c]) * $signed(vec[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < 2; i++) begin
				pair_s2[i] <= hvt_pkg::PAIR_W'(prod_s1[2*i]) + hvt_pkg::PAIR_W'(prod_s1[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			acc_s3 <= hvt_pkg::ACC_W'(pair_s2[0]) + hvt_pkg::ACC_W'(pair_s2[1]);
		end
	end

	// floor shift, then clip when the bits above the result are not a sign run
	assign shifted  = acc_s3 >>> hvt_pkg::FRAC_BITS;
	assign top_bits = shifted[hvt_pkg::ACC_W-1:hvt_pkg::WORD_W-1];

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if ((&top_bits) || !(|top_bits)) begin
				res_s4 <= shifted[hvt_pkg::WORD_W-1:0];
				sat_s4 <= 1'b0;
			end else begin
				res_s4 <= shifted[hvt_pkg::ACC_W-1] ? hvt_pkg::WORD_MIN : hvt_pkg::WORD_MAX;
				sat_s4 <= 1'b1;
			end
		end
	end

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

>>> src/homogeneous_vertex_transform.sv
`timescale 1ns / 1ps
// a beat accepted at the input passes four register stages (multiply, pair add,
// final add, shift and clip) before it is offered; throughput: one vertex per cycle
// while m_axis_tready is high, each stage moving on when the stage after it is free
// reset: arst_n clears every stage valid bit and loads the identity matrix
// into the eight coefficient registers; datapath registers are not reset
module homogeneous_vertex_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	// input vertex stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [127:0]                  s_axis_tdata,  // x_in, y_in, z_in, w_in
	input  logic                          s_axis_tuser,  // kind
	// output vertex stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [127:0]                  m_axis_tdata,  // x_out, y_out, z_out, w_out
	output logic                          m_axis_tuser,  // saturated
	// matrix register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hvt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hvt_pkg::REG_W-1:0]     cfg_data
);

	hvt_pkg::matrix_t          matrix;
	hvt_pkg::vec_t             vec;
	hvt_pkg::stage_en_t        en;
	logic [hvt_pkg::NUM_ROWS-1:0]                    row_sat;
	logic [hvt_pkg::NUM_ROWS-1:0][hvt_pkg::WORD_W-1:0] row_res;

	// one valid bit per stage, travelling with the row datapaths
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	hvt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.matrix   (matrix)
	);

	// components in beat order; a point takes w as 1.0
	always_comb begin
		for (int c = 0; c < hvt_pkg::NUM_COLS - 1; c++) begin
			vec[c] = s_axis_tdata[c*hvt_pkg::WORD_W +: hvt_pkg::WORD_W];
		end
		vec[hvt_pkg::NUM_COLS-1] = (s_axis_tuser == hvt_pkg::KIND_POINT)
			? hvt_pkg::WORD_ONE
			: s_axis_tdata[(hvt_pkg::NUM_COLS-1)*hvt_pkg::WORD_W +: hvt_pkg::WORD_W];
	end

	// a stage can load when it is empty or its beat moves on this cycle,
	// so bubbles fill even while the output beat is held
	assign rdy4 = !valid_s4 || m_axis_tready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign s_axis_tready = rdy1;

	assign en.s1 = s_axis_tvalid && rdy1;
	assign en.s2 = valid_s1 && rdy2;
	assign en.s3 = valid_s2 && rdy3;
	assign en.s4 = valid_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_axis_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// one dot product pipeline per output row
	for (genvar r = 0; r < hvt_pkg::NUM_ROWS; r++) begin : g_row
		hvt_row u_row (
			.clk  (clk),
			.en   (en),
			.coef (matrix[r]),
			.vec  (vec),
			.res  (row_res[r]),
			.sat  (row_sat[r])
		);
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = row_res;
	assign m_axis_tuser  = |row_sat;

	// input is held back only when every stage is full and the output stalls
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// a new output beat must come from the final add stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(valid_s3))
		else $error("output beat appeared without a beat in stage three");

	// a raised saturation flag means some component sits at a clip value
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			(m_axis_tdata[31:0] == hvt_pkg::WORD_MAX || m_axis_tdata[31:0] == hvt_pkg::WORD_MIN ||
			 m_axis_tdata[63:32] == hvt_pkg::WORD_MAX || m_axis_tdata[63:32] == hvt_pkg::WORD_MIN ||
			 m_axis_tdata[95:64] == hvt_pkg::WORD_MAX || m_axis_tdata[95:64] == hvt_pkg::WORD_MIN ||
			 m_axis_tdata[127:96] == hvt_pkg::WORD_MAX || m_axis_tdata[127:96] == hvt_pkg::WORD_MIN))
		else $error("saturation flag without a clipped component");

endmodule

>>> dv/tb_homogeneous_vertex_transform.sv
`timescale 1ns / 1ps

module tb_homogeneous_vertex_transform;
	import hvt_pkg::*;

	localparam int LATENCY     = 4;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AFTER  = 300;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_BEATS = 116;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 200000;

	// clip bounds of one row sum after the shift
	localparam logic signed [ACC_W-1:0] ROW_MAX = 66'sh0_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] ROW_MIN = -66'sh0_8000_0000;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] reg_set_t;

	// one output beat, fields in port order
	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] w;
		logic              sat;
	} vertex_out_t;

	// matrices used by the directed table
	typedef enum logic [1:0] {
		MAT_IDENTITY,
		MAT_ALL_MAX,
		MAT_ALL_MIN,
		MAT_MIXED
	} mat_sel_t;

	typedef struct {
		mat_sel_t          mat;
		logic              kind;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] w;
		bit                typed;
		vertex_out_t       result;
	} stim_row_t;

	localparam int NUM_DIRECTED = 20;

	// rows marked typed carry a result that follows from the matrix at a glance;
	// the others are left to the predictor
	stim_row_t directed [NUM_DIRECTED] = '{
		// identity after reset: components come back untouched, points get w = 1.0
		'{MAT_IDENTITY, KIND_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h1234_5678, 1'b1,
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0}},
		'{MAT_IDENTITY, KIND_TUPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1,
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
		'{MAT_IDENTITY, KIND_TUPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 1'b1,
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
		'{MAT_IDENTITY, KIND_POINT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 1'b1,
			'{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0}},
		'{MAT_IDENTITY, KIND_TUPLE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
			32'h0000_0000, 1'b1,
			'{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0000, 1'b0}},
		'{MAT_IDENTITY, KIND_TUPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1,
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
		// all coefficients at the positive limit
		'{MAT_ALL_MAX, KIND_TUPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1'b1,
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}},
		'{MAT_ALL_MAX, KIND_TUPLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b1,
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1}},
		'{MAT_ALL_MAX, KIND_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h8000_0000, 1'b1,
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}},
		'{MAT_ALL_MAX, KIND_TUPLE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 1'b1,
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}},
		'{MAT_ALL_MAX, KIND_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'h7FFF_FFFF, 1'b0, '0},
		'{MAT_ALL_MAX, KIND_TUPLE, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
			32'h0000_0001, 1'b0, '0},
		// all coefficients at the negative limit
		'{MAT_ALL_MIN, KIND_TUPLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b1,
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}},
		'{MAT_ALL_MIN, KIND_TUPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1'b1,
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1}},
		'{MAT_ALL_MIN, KIND_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h7FFF_FFFF, 1'b1,
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}},
		'{MAT_ALL_MIN, KIND_TUPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b0, '0},
		'{MAT_ALL_MIN, KIND_POINT, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0000, 1'b0, '0},
		// some rows clip while the others stay in range, odd negatives round down
		'{MAT_MIXED, KIND_TUPLE, 32'h4000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 1'b0, '0},
		'{MAT_MIXED, KIND_TUPLE, 32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0003,
			32'hFFFF_0000, 1'b0, '0},
		'{MAT_MIXED, KIND_POINT, 32'hC000_0000, 32'h0000_0000, 32'h8000_0001,
			32'h5555_5555, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [127:0]         s_axis_tdata;   // x_in, y_in, z_in, w_in
	logic                 s_axis_tuser;   // kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [127:0]         m_axis_tdata;   // x_out, y_out, z_out, w_out
	logic                 m_axis_tuser;   // saturated
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	// predictor copy of the coefficient registers, identity out of reset
	reg_set_t    coef_regs = CFG_RESET;
	vertex_out_t expected_vertices [$];
	int          fail_count = 0;
	int          beats_out = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;
	bit          long_hold_done = 1'b0;

	homogeneous_vertex_transform dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected",
				cycle_count, expected_vertices.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// exact 4x4 product: full 64-bit products, 66-bit sum, floor shift, clip per row
	function automatic vertex_out_t transform_vertex(logic kind, logic [WORD_W-1:0] x,
			logic [WORD_W-1:0] y, logic [WORD_W-1:0] z, logic [WORD_W-1:0] w);
		logic signed [WORD_W-1:0] comp [NUM_COLS];
		logic signed [WORD_W-1:0] coef;
		logic signed [PROD_W-1:0] prod;
		logic signed [ACC_W-1:0]  acc;
		logic signed [ACC_W-1:0]  shifted;
		logic [REG_W-1:0]         reg_word;
		logic [WORD_W-1:0]        row_out [NUM_ROWS];
		logic                     sat;
		vertex_out_t              res;
		comp[0] = x;
		comp[1] = y;
		comp[2] = z;
		// points ignore w_in and use 1.0
		comp[3] = (kind == KIND_POINT) ? WORD_ONE : w;
		sat = 1'b0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			acc = '0;
			for (int c = 0; c < NUM_COLS; c++) begin
				reg_word = coef_regs[2 * r + c / 2];
				coef = (c % 2 == 1) ? reg_word[REG_W-1:WORD_W] : reg_word[WORD_W-1:0];
				prod = coef * comp[c];
				acc = acc + prod;
			end
			shifted = acc >>> FRAC_BITS;
			if (shifted > ROW_MAX) begin
				row_out[r] = WORD_MAX;
				sat = 1'b1;
			end else if (shifted < ROW_MIN) begin
				row_out[r] = WORD_MIN;
				sat = 1'b1;
			end else begin
				row_out[r] = shifted[WORD_W-1:0];
			end
		end
		res = '{row_out[0], row_out[1], row_out[2], row_out[3], sat};
		return res;
	endfunction

	// mostly small signed values, some full-range words, a few limits
	function automatic logic [WORD_W-1:0] random_word(int small_w);
		logic [WORD_W-1:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			7, 8: return raw;
			9: begin
				case ($urandom_range(0, 3))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $signed(raw << (WORD_W - small_w)) >>> (WORD_W - small_w);
		endcase
	endfunction

	// one beat on the config channel; cfg_valid stays up for a back-to-back write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS)
			coef_regs[idx] = value;
	endtask

	// all eight registers, then a write past the last index that must be dropped
	task automatic load_matrix(reg_set_t values);
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i[CFG_IDX_W-1:0], values[i]);
		write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)),
			{$urandom, $urandom});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic reg_set_t directed_matrix(mat_sel_t sel);
		reg_set_t m;
		case (sel)
			MAT_ALL_MAX: m = {NUM_REGS{WORD_MAX, WORD_MAX}};
			MAT_ALL_MIN: m = {NUM_REGS{WORD_MIN, WORD_MIN}};
			MAT_MIXED: begin
				m = '0;
				m[0] = {32'h0000_0000, 32'h0002_0000};  // x times 2.0
				m[2] = {32'hFFFF_0000, 32'h0000_0000};  // y times -1.0
				m[5] = {32'h0000_0000, 32'h0000_8000};  // z times 0.5
				m[7] = {32'hFFFF_FFFF, 32'h0000_0000};  // w times minus one lsb
			end
			default: m = CFG_RESET;
		endcase
		return m;
	endfunction

	// drop valid and let the pipe drain before touching the matrix
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// offer one vertex beat after a random gap; the expected beat is queued at acceptance
	task automatic send_vertex(logic kind, logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
			logic [WORD_W-1:0] z, logic [WORD_W-1:0] w, bit typed, vertex_out_t result);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w, z, y, x};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		if (typed)
			expected_vertices.push_back(result);
		else
			expected_vertices.push_back(transform_vertex(kind, x, y, z, w));
	endtask

	// stimulus: directed table, then random phases with a fresh matrix each
	initial begin : vertex_source
		mat_sel_t cur_mat;
		reg_set_t values;
		int       style;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_TUPLE;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, the matrix is reloaded only when the table asks for another
		cur_mat = MAT_IDENTITY;
		foreach (directed[i]) begin
			if (directed[i].mat != cur_mat) begin
				wait_idle();
				load_matrix(directed_matrix(directed[i].mat));
				cur_mat = directed[i].mat;
			end
			send_vertex(directed[i].kind, directed[i].x, directed[i].y, directed[i].z,
				directed[i].w, directed[i].typed, directed[i].result);
		end

		// random part; every phase boundary is a full drain of the pipe
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_idle();
			style = (phase == 0) ? 0 : $urandom_range(0, 3);
			for (int i = 0; i < NUM_REGS; i++) begin
				case (style)
					0: values[i] = CFG_RESET[i];
					1: values[i] = {$urandom, $urandom};
					default: values[i] = {random_word(18), random_word(18)};
				endcase
			end
			load_matrix(values);
			// every third phase runs with both sides at full rate
			no_idle = (phase % 3 == 2);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				send_vertex($urandom_range(0, 1) ? KIND_POINT : KIND_TUPLE,
					random_word(24), random_word(24), random_word(24), random_word(24),
					1'b0, '0);
			end
		end

		// drain, then let the pipe run on so that any stray beat shows
		s_axis_tvalid <= 1'b0;
		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (expected_vertices.size() != 0) begin
			$display("%0d expected beats never arrived", expected_vertices.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// output side: random stalls per beat, one long hold-off to back up the pipe
	initial begin : result_sink
		int          stall;
		vertex_out_t got;
		vertex_out_t want;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && beats_out >= HOLD_AFTER) begin
				// sender keeps offering; s_axis_tready has to fall while we sit here
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 5);
				repeat (stall) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
				m_axis_tdata[127:96], m_axis_tuser};
			if (expected_vertices.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected beat %0d: x=%h y=%h z=%h w=%h sat=%b",
						beats_out, got.x, got.y, got.z, got.w, got.sat);
			end else begin
				want = expected_vertices.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("beat %0d mismatch: exp x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
							beats_out, want.x, want.y, want.z, want.w, want.sat,
							got.x, got.y, got.z, got.w, got.sat);
				end
			end
			beats_out++;
		end
	end

endmodule

>>> sim.f
src/hvt_pkg.sv
src/hvt_cfg.sv
src/hvt_row.sv
src/homogeneous_vertex_transform.sv
dv/tb_homogeneous_vertex_transform.sv
